>>> rtl/refcounted_page_allocator_defines.svh
// Assertion macros used by the checker file of the page allocator.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef REFCOUNTED_PAGE_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RPA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RPA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/rpa_pkg.sv
// Shared constants, codes and control types of the page allocator.
// Used by every module of the block; depends on nothing.
package rpa_pkg;

   localparam int NUM_PAGES       = 4096;
   localparam int COUNT_BITS      = 8;
   localparam int PAGE_SHIFT      = 12;
   localparam int ADDR_BITS       = 40;
   localparam int IDX_BITS        = $clog2(NUM_PAGES);
   localparam int DEPTH_BITS      = 13;
   localparam int PAGE_FIELD_BITS = ADDR_BITS - PAGE_SHIFT;
   localparam int ACTION_BITS     = 2;
   localparam int STATUS_BITS     = 3;
   localparam int CSR_INDEX_BITS  = 1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [ADDR_BITS-1:0] REGION_BASE_RESET = 40'h00_8000_0000;
   localparam logic [ADDR_BITS-1:0] REGION_LAST_RESET = 40'h00_8100_0000;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_REGION_BASE = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REGION_LAST = 1'b1;

   localparam logic [ACTION_BITS-1:0] ACT_ALLOC  = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_FREE   = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_ADDREF = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_DONE      = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_NOROOM    = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_UNALIGNED = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_RANGE     = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_ZERO      = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_OVERFLOW  = 3'd5;
   localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd6;

   typedef struct packed {
      logic                clear_wr;
      logic [IDX_BITS-1:0] clear_idx;
      logic                accept;
      logic                fetch;
      logic                commit;
   } rpa_cmd_type;

   typedef struct packed {
      logic req_is_alloc;
   } rpa_sts_type;

endpackage

>>> rtl/rpa_ctrl.sv
// Controller of the page allocator: count clearing pass, request sequencing
// and the result word handshake. Depends on rpa_pkg.
module rpa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rpa_pkg::rpa_sts_type sts,
   output rpa_pkg::rpa_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_FETCH,
      S_EXEC
   } state_type;

   state_type                     state_ff, state_in;
   logic [rpa_pkg::IDX_BITS-1:0]  clear_idx_ff, clear_idx_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in      = state_ff;
      clear_idx_in  = clear_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd           = '0;
      cmd.clear_idx = clear_idx_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            clear_idx_in = clear_idx_ff + rpa_pkg::IDX_BITS'(1);
            if (clear_idx_ff == rpa_pkg::IDX_BITS'(rpa_pkg::NUM_PAGES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = sts.req_is_alloc ? S_FETCH : S_EXEC;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_EXEC;
         end
         S_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clear_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/rpa_datapath.sv
// Datapath of the page allocator: region registers, address check, count and
// free stack memories, stack depth and the result word register. Depends on rpa_pkg.
module rpa_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [rpa_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rpa_pkg::ADDR_BITS-1:0]       csr_wr_data,
   input  logic [rpa_pkg::ACTION_BITS-1:0]     req_action,
   input  logic [rpa_pkg::ADDR_BITS-1:0]       req_page_address,
   output logic [rpa_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic [rpa_pkg::ADDR_BITS-1:0]       rsp_granted_address,
   output logic [rpa_pkg::DEPTH_BITS-1:0]      rsp_free_count,
   input  rpa_pkg::rpa_cmd_type                cmd,
   output rpa_pkg::rpa_sts_type                sts
);

   logic [rpa_pkg::ADDR_BITS-1:0]   region_base_ff, region_last_ff;
   logic [rpa_pkg::ACTION_BITS-1:0] action_ff;
   logic [rpa_pkg::STATUS_BITS-1:0] loc_status_ff;
   logic [rpa_pkg::IDX_BITS-1:0]    idx_ff;
   logic [rpa_pkg::DEPTH_BITS-1:0]  depth_ff, depth_in;

   logic [rpa_pkg::COUNT_BITS-1:0]  cnt_mem [rpa_pkg::NUM_PAGES];
   logic [rpa_pkg::COUNT_BITS-1:0]  cnt_rd_ff;
   logic [rpa_pkg::IDX_BITS-1:0]    stk_mem [rpa_pkg::NUM_PAGES];
   logic [rpa_pkg::IDX_BITS-1:0]    stk_rd_ff;

   logic [rpa_pkg::STATUS_BITS-1:0] rsp_status_ff;
   logic [rpa_pkg::ADDR_BITS-1:0]   rsp_granted_ff;
   logic [rpa_pkg::DEPTH_BITS-1:0]  rsp_free_count_ff;

   logic [rpa_pkg::ADDR_BITS-1:0]   offset;
   logic                            unaligned, out_range;
   logic [rpa_pkg::STATUS_BITS-1:0] loc_status;
   logic [rpa_pkg::IDX_BITS-1:0]    loc_idx;

   logic [rpa_pkg::STATUS_BITS-1:0] res_status;
   logic [rpa_pkg::ADDR_BITS-1:0]   res_grant;
   logic                            res_cnt_wr, res_push;
   logic [rpa_pkg::COUNT_BITS-1:0]  res_cnt_data;

   logic                            cnt_we, cnt_re;
   logic [rpa_pkg::IDX_BITS-1:0]    cnt_wa, cnt_ra;
   logic [rpa_pkg::COUNT_BITS-1:0]  cnt_wd;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_base_ff <= rpa_pkg::REGION_BASE_RESET;
         region_last_ff <= rpa_pkg::REGION_LAST_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rpa_pkg::CSR_REGION_BASE: region_base_ff <= csr_wr_data;
            rpa_pkg::CSR_REGION_LAST: region_last_ff <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   assign sts.req_is_alloc = (req_action == rpa_pkg::ACT_ALLOC);

   always_comb begin
      offset    = req_page_address - region_base_ff;
      unaligned = |req_page_address[rpa_pkg::PAGE_SHIFT-1:0];
      out_range = (req_page_address < region_base_ff)
               || (req_page_address > region_last_ff)
               || (offset[rpa_pkg::ADDR_BITS-1:rpa_pkg::PAGE_SHIFT]
                   >= rpa_pkg::PAGE_FIELD_BITS'(rpa_pkg::NUM_PAGES));
      loc_idx   = offset[rpa_pkg::PAGE_SHIFT +: rpa_pkg::IDX_BITS];
      if (unaligned) begin
         loc_status = rpa_pkg::ST_UNALIGNED;
      end else if (out_range) begin
         loc_status = rpa_pkg::ST_RANGE;
      end else begin
         loc_status = rpa_pkg::ST_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         action_ff     <= req_action;
         loc_status_ff <= loc_status;
         idx_ff        <= loc_idx;
      end else if (cmd.fetch) begin
         idx_ff <= stk_rd_ff;
      end
   end

   always_comb begin
      res_status   = rpa_pkg::ST_DONE;
      res_grant    = '0;
      res_cnt_wr   = 1'b0;
      res_push     = 1'b0;
      res_cnt_data = cnt_rd_ff;
      depth_in     = depth_ff;
      case (action_ff)
         rpa_pkg::ACT_ALLOC: begin
            if (depth_ff == '0) begin
               res_status = rpa_pkg::ST_NOROOM;
            end else if (cnt_rd_ff == rpa_pkg::COUNT_MAX) begin
               res_status = rpa_pkg::ST_OVERFLOW;
            end else begin
               depth_in     = depth_ff - rpa_pkg::DEPTH_BITS'(1);
               res_cnt_wr   = 1'b1;
               res_cnt_data = cnt_rd_ff + rpa_pkg::COUNT_BITS'(1);
               res_grant    = region_base_ff
                            + (rpa_pkg::ADDR_BITS'(idx_ff) << rpa_pkg::PAGE_SHIFT);
            end
         end
         rpa_pkg::ACT_FREE: begin
            if (loc_status_ff != rpa_pkg::ST_DONE) begin
               res_status = loc_status_ff;
            end else if (cnt_rd_ff == '0) begin
               res_status = rpa_pkg::ST_ZERO;
            end else if (cnt_rd_ff == rpa_pkg::COUNT_BITS'(1)) begin
               if (depth_ff == rpa_pkg::DEPTH_BITS'(rpa_pkg::NUM_PAGES)) begin
                  res_status = rpa_pkg::ST_FULL;
               end else begin
                  res_cnt_wr   = 1'b1;
                  res_cnt_data = '0;
                  res_push     = 1'b1;
                  depth_in     = depth_ff + rpa_pkg::DEPTH_BITS'(1);
               end
            end else begin
               res_cnt_wr   = 1'b1;
               res_cnt_data = cnt_rd_ff - rpa_pkg::COUNT_BITS'(1);
            end
         end
         rpa_pkg::ACT_ADDREF: begin
            if (loc_status_ff != rpa_pkg::ST_DONE) begin
               res_status = loc_status_ff;
            end else if (cnt_rd_ff == rpa_pkg::COUNT_MAX) begin
               res_status = rpa_pkg::ST_OVERFLOW;
            end else begin
               res_cnt_wr   = 1'b1;
               res_cnt_data = cnt_rd_ff + rpa_pkg::COUNT_BITS'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      cnt_we = cmd.clear_wr || (cmd.commit && res_cnt_wr);
      cnt_wa = cmd.clear_wr ? cmd.clear_idx : idx_ff;
      cnt_wd = cmd.clear_wr ? rpa_pkg::COUNT_BITS'(1) : res_cnt_data;
      cnt_re = cmd.accept || cmd.fetch;
      cnt_ra = cmd.fetch ? stk_rd_ff : loc_idx;
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      if (cnt_re) begin
         cnt_rd_ff <= cnt_mem[cnt_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && res_push) begin
         stk_mem[depth_ff[rpa_pkg::IDX_BITS-1:0]] <= idx_ff;
      end
      if (cmd.accept) begin
         stk_rd_ff <= stk_mem[rpa_pkg::IDX_BITS'(depth_ff - rpa_pkg::DEPTH_BITS'(1))];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else if (cmd.commit) begin
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff     <= res_status;
         rsp_granted_ff    <= res_grant;
         rsp_free_count_ff <= depth_in;
      end
   end

   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_address = rsp_granted_ff;
   assign rsp_free_count      = rsp_free_count_ff;

endmodule

>>> rtl/refcounted_page_allocator.sv
// Page allocator top level. Free and add-reference words read the count at
// acceptance and update it in the execute state; allocate reads the stack, then
// the count, then updates it. One word is in flight at a time; the result register
// lets the next word enter while a result waits to be taken.
// After reset a clearing pass over all 4096 counts sets every count to one; no word is
// accepted meanwhile, configuration writes are. Depends on rpa_ctrl, rpa_datapath.
module refcounted_page_allocator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [rpa_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rpa_pkg::ADDR_BITS-1:0]       csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [rpa_pkg::ACTION_BITS-1:0]     req_action,
   input  logic [rpa_pkg::ADDR_BITS-1:0]       req_page_address,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rpa_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic [rpa_pkg::ADDR_BITS-1:0]       rsp_granted_address,
   output logic [rpa_pkg::DEPTH_BITS-1:0]      rsp_free_count
);

   rpa_pkg::rpa_cmd_type cmd;
   rpa_pkg::rpa_sts_type sts;

   rpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rpa_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .req_action          (req_action),
      .req_page_address    (req_page_address),
      .rsp_status          (rsp_status),
      .rsp_granted_address (rsp_granted_address),
      .rsp_free_count      (rsp_free_count),
      .cmd                 (cmd),
      .sts                 (sts)
   );

endmodule

>>> rtl/rpa_checker.sv
// Port-level checker of the page allocator and its bind to the top level.
// Depends on rpa_pkg and refcounted_page_allocator_defines.svh.
`include "refcounted_page_allocator_defines.svh"

module rpa_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [rpa_pkg::STATUS_BITS-1:0]     rsp_status,
   input logic [rpa_pkg::ADDR_BITS-1:0]       rsp_granted_address,
   input logic [rpa_pkg::DEPTH_BITS-1:0]      rsp_free_count
);

   `RPA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status), "result word dropped or changed while stalled")
   `RPA_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "second word accepted before the first finished")
   `RPA_ASSERT_NOW(a_grant_only_done, rsp_valid && (rsp_status != rpa_pkg::ST_DONE), rsp_granted_address == '0, "address granted on a failed word")
   `RPA_ASSERT_NOW(a_status_code, rsp_valid, rsp_status <= rpa_pkg::ST_FULL, "undefined status code")
   `RPA_ASSERT_NOW(a_depth_bound, rsp_valid, rsp_free_count <= rpa_pkg::DEPTH_BITS'(rpa_pkg::NUM_PAGES), "free stack deeper than the page count")

endmodule

bind refcounted_page_allocator rpa_checker u_rpa_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_status          (rsp_status),
   .rsp_granted_address (rsp_granted_address),
   .rsp_free_count      (rsp_free_count)
);

>>> bench/refcounted_page_allocator_tb.sv
// Self-checking testbench for the reference-counted page allocator: it drives
// allocate, free, add-reference and spare-code words, predicts each answer and checks it.
// Depends on rpa_pkg and the refcounted_page_allocator RTL.
module refcounted_page_allocator_tb;
   import rpa_pkg::*;

   localparam logic [ACTION_BITS-1:0] ACT_SPARE = 2'd3;
   localparam logic [ADDR_BITS-1:0] PAGE_LOW = 40'hFFF;
   localparam logic [ADDR_BITS-1:0] PAGE_STEP = 40'h1000;
   localparam int POOL_PAGES = 16;
   localparam int LONG_HOLD_AT = 600;
   localparam int LONG_HOLD_CYCLES = 300;

   typedef struct packed {
      logic [ACTION_BITS-1:0] action;
      logic [ADDR_BITS-1:0]   page_address;
   } page_req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [ADDR_BITS-1:0]   granted_address;
      logic [DEPTH_BITS-1:0]  free_count;
   } alloc_answer_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [ADDR_BITS-1:0]      csr_wr_data = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [ACTION_BITS-1:0]    req_action = '0;
   logic [ADDR_BITS-1:0]      req_page_address = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [STATUS_BITS-1:0]    rsp_status;
   logic [ADDR_BITS-1:0]      rsp_granted_address;
   logic [DEPTH_BITS-1:0]     rsp_free_count;

   // Shadow copy of the allocator state and its region registers.
   logic [ADDR_BITS-1:0]  base_copy;
   logic [ADDR_BITS-1:0]  last_copy;
   logic [COUNT_BITS-1:0] page_refs [NUM_PAGES];
   logic [IDX_BITS-1:0]   stack_copy [NUM_PAGES];
   logic [DEPTH_BITS-1:0] stack_fill;

   page_req_type     requests_waiting [$];
   alloc_answer_type answers_due [$];

   bit          pace_on = 1'b1;
   int unsigned words_offered = 0;
   int unsigned words_accepted = 0;
   int unsigned answers_taken = 0;
   int unsigned taken_seen = 0;
   int unsigned send_gap = 0;
   int unsigned rsp_gap = 0;
   int unsigned hold_left = 0;
   int unsigned mismatches = 0;

   refcounted_page_allocator dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_page_address    (req_page_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_granted_address (rsp_granted_address),
      .rsp_free_count      (rsp_free_count)
   );

   always #6 clock = ~clock;

   function automatic logic [STATUS_BITS-1:0] find_page(input logic [ADDR_BITS-1:0] addr,
                                                        output logic [IDX_BITS-1:0] idx);
      logic [ADDR_BITS-1:0] offset;
      idx = '0;
      offset = addr - base_copy;
      if (addr[PAGE_SHIFT-1:0] != '0) return ST_UNALIGNED;
      if (addr < base_copy || addr > last_copy) return ST_RANGE;
      if ((offset >> PAGE_SHIFT) >= NUM_PAGES) return ST_RANGE;
      idx = offset[PAGE_SHIFT +: IDX_BITS];
      return ST_DONE;
   endfunction

   function automatic alloc_answer_type apply_request(input logic [ACTION_BITS-1:0] act,
                                                      input logic [ADDR_BITS-1:0] addr);
      alloc_answer_type     ans;
      logic [IDX_BITS-1:0]  idx;
      logic [ADDR_BITS-1:0] idx_wide;
      ans = '0;
      ans.status = ST_DONE;
      case (act)
         ACT_ALLOC: begin
            if (stack_fill == '0) begin
               ans.status = ST_NOROOM;
            end else begin
               idx = stack_copy[stack_fill - 1'b1];
               if (page_refs[idx] == COUNT_MAX) begin
                  ans.status = ST_OVERFLOW;
               end else begin
                  stack_fill = stack_fill - 1'b1;
                  page_refs[idx] = page_refs[idx] + 1'b1;
                  idx_wide = idx;
                  ans.granted_address = base_copy + (idx_wide << PAGE_SHIFT);
               end
            end
         end
         ACT_FREE: begin
            ans.status = find_page(addr, idx);
            if (ans.status == ST_DONE) begin
               if (page_refs[idx] == '0) begin
                  ans.status = ST_ZERO;
               end else if (page_refs[idx] == 1) begin
                  if (stack_fill >= NUM_PAGES) begin
                     ans.status = ST_FULL;
                  end else begin
                     page_refs[idx] = '0;
                     stack_copy[stack_fill] = idx;
                     stack_fill = stack_fill + 1'b1;
                  end
               end else begin
                  page_refs[idx] = page_refs[idx] - 1'b1;
               end
            end
         end
         ACT_ADDREF: begin
            ans.status = find_page(addr, idx);
            if (ans.status == ST_DONE) begin
               if (page_refs[idx] == COUNT_MAX) ans.status = ST_OVERFLOW;
               else page_refs[idx] = page_refs[idx] + 1'b1;
            end
         end
         default: ;
      endcase
      ans.free_count = stack_fill;
      return ans;
   endfunction

   function automatic void check_field(input string name, input logic [ADDR_BITS-1:0] want,
                                       input logic [ADDR_BITS-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void queue_word(input logic [ACTION_BITS-1:0] act,
                                      input logic [ADDR_BITS-1:0] addr);
      page_req_type w;
      w.action = act;
      w.page_address = addr;
      requests_waiting.push_back(w);
   endfunction

   // Mostly aligned pages from a small pool at the bottom of the region, so that
   // counts reach zero and pages return to the stack; the rest probes the edges.
   function automatic logic [ADDR_BITS-1:0] pick_address();
      logic [ADDR_BITS-1:0] first_page;
      logic [ADDR_BITS-1:0] step;
      logic [ADDR_BITS-1:0] addr;
      int unsigned          sel;
      first_page = (base_copy + PAGE_LOW) & ~PAGE_LOW;
      step = $urandom_range(0, POOL_PAGES - 1);
      addr = first_page + (step << PAGE_SHIFT);
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
         addr[31:0] = $urandom;
         addr[ADDR_BITS-1:32] = $urandom_range(0, 255);
      end else if (sel < 14) begin
         addr[PAGE_SHIFT-1:0] = $urandom_range(1, 4095);
      end else if (sel < 18) begin
         addr = first_page - PAGE_STEP;
      end else if (sel < 22) begin
         addr = (last_copy & ~PAGE_LOW) + PAGE_STEP;
      end else if (sel < 26) begin
         addr = last_copy & ~PAGE_LOW;
      end
      return addr;
   endfunction

   task automatic queue_random(input int count);
      int unsigned            sel;
      logic [ACTION_BITS-1:0] act;
      repeat (count) begin
         sel = $urandom_range(0, 99);
         if (sel < 30) act = ACT_ALLOC;
         else if (sel < 63) act = ACT_FREE;
         else if (sel < 94) act = ACT_ADDREF;
         else act = ACT_SPARE;
         queue_word(act, pick_address());
      end
   endtask

   task automatic write_region(input logic [CSR_INDEX_BITS-1:0] which,
                               input logic [ADDR_BITS-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= which;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (which == CSR_REGION_BASE) base_copy = value;
      else last_copy = value;
   endtask

   task automatic wait_quiet();
      while (requests_waiting.size() != 0 || req_valid || answers_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   always @(negedge clock) begin : req_side
      page_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (words_accepted == words_offered) begin
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (requests_waiting.size() != 0) begin
            nxt = requests_waiting.pop_front();
            req_valid <= 1'b1;
            req_action <= nxt.action;
            req_page_address <= nxt.page_address;
            words_offered <= words_offered + 1;
            send_gap <= pace_on ? $urandom_range(0, 7) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : rsp_side
      int unsigned pause;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (taken_seen != answers_taken) begin
         pause = pace_on ? $urandom_range(0, 7) : 0;
         taken_seen <= answers_taken;
         if (answers_taken == LONG_HOLD_AT) begin
            hold_left <= LONG_HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_gap <= (pause == 0) ? 0 : pause - 1;
            rsp_ready <= (pause == 0);
         end
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (rsp_gap != 0) begin
         rsp_gap <= rsp_gap - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : answer_check
      alloc_answer_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            answers_taken <= answers_taken + 1;
            if (answers_due.size() == 0) begin
               $error("result word with no request outstanding");
               mismatches++;
            end else begin
               want = answers_due.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("granted_address", want.granted_address, rsp_granted_address);
               check_field("free_count", want.free_count, rsp_free_count);
            end
         end
         if (req_valid && req_ready) begin
            answers_due.push_back(apply_request(req_action, req_page_address));
            words_accepted <= words_accepted + 1;
         end
      end
   end

   initial begin : stimulus
      logic [ADDR_BITS-1:0] base_pick;
      logic [ADDR_BITS-1:0] hot_page;
      base_copy = REGION_BASE_RESET;
      last_copy = REGION_LAST_RESET;
      stack_fill = '0;
      for (int k = 0; k < NUM_PAGES; k++) begin
         page_refs[k] = 1;
         stack_copy[k] = '0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words under the reset region.
      queue_word(ACT_ALLOC, '0);
      queue_word(ACT_FREE, REGION_BASE_RESET);
      queue_word(ACT_FREE, REGION_BASE_RESET);
      queue_word(ACT_ADDREF, REGION_BASE_RESET);
      queue_word(ACT_FREE, REGION_BASE_RESET);
      queue_word(ACT_ALLOC, '0);
      queue_word(ACT_ALLOC, 40'hFF_FFFF_FFFF);
      queue_word(ACT_ALLOC, '0);
      queue_word(ACT_FREE, REGION_BASE_RESET + 1);
      queue_word(ACT_ADDREF, REGION_BASE_RESET + 40'h800);
      queue_word(ACT_FREE, REGION_BASE_RESET - PAGE_STEP);
      queue_word(ACT_ADDREF, REGION_LAST_RESET);
      queue_word(ACT_FREE, REGION_LAST_RESET - PAGE_STEP);
      queue_word(ACT_ADDREF, 40'hFF_FFFF_F000);
      queue_word(ACT_FREE, '0);
      queue_word(ACT_ADDREF, 40'hFF_FFFF_FFFF);
      queue_word(ACT_SPARE, 40'hA5_5A5A_5A5A);
      queue_word(ACT_ALLOC, '0);
      queue_word(ACT_FREE, REGION_BASE_RESET + PAGE_STEP);
      queue_word(ACT_ADDREF, REGION_BASE_RESET + 2 * PAGE_STEP);
      queue_word(ACT_FREE, REGION_BASE_RESET + 2 * PAGE_STEP);
      queue_word(ACT_SPARE, '0);
      wait_quiet();

      // A page on top of the stack driven up to the count limit.
      hot_page = REGION_BASE_RESET + 3 * PAGE_STEP;
      queue_word(ACT_FREE, hot_page);
      repeat (256) queue_word(ACT_ADDREF, hot_page);
      queue_word(ACT_ALLOC, '0);
      queue_word(ACT_FREE, hot_page);
      queue_word(ACT_ALLOC, '0);
      queue_word(ACT_ALLOC, '0);
      wait_quiet();

      write_region(CSR_REGION_BASE, 40'h00_8000_0000);
      write_region(CSR_REGION_LAST, 40'h00_8000_F000);
      queue_random(200);
      wait_quiet();

      pace_on = 1'b0;
      write_region(CSR_REGION_BASE, '0);
      write_region(CSR_REGION_LAST, 40'hFF_FFFF_FFFF);
      queue_random(200);
      wait_quiet();

      pace_on = 1'b1;
      write_region(CSR_REGION_BASE, 40'hFF_FFFF_F000);
      queue_random(200);
      wait_quiet();

      base_pick = $urandom_range(0, 32'h0FFF_FFFF);
      write_region(CSR_REGION_BASE, base_pick);
      write_region(CSR_REGION_LAST, base_pick + $urandom_range(32'h1000, 32'h2_0000));
      queue_random(200);
      wait_quiet();

      write_region(CSR_REGION_BASE, 40'h10_0000_0000);
      write_region(CSR_REGION_LAST, 40'h0F_FFFF_F000);
      queue_random(150);
      wait_quiet();

      write_region(CSR_REGION_BASE, '0);
      write_region(CSR_REGION_LAST, '0);
      queue_random(200);
      wait_quiet();

      write_region(CSR_REGION_BASE, REGION_BASE_RESET);
      write_region(CSR_REGION_LAST, REGION_LAST_RESET);
      queue_random(120);
      wait_quiet();

      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("** refcounted_page_allocator: PASSED **");
      else
         $display("** refcounted_page_allocator: FAILED **");
      $finish;
   end

   initial begin : watchdog
      #10000000;
      $display("** refcounted_page_allocator: FAILED **");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/rpa_pkg.sv
rtl/rpa_ctrl.sv
rtl/rpa_datapath.sv
rtl/refcounted_page_allocator.sv
rtl/rpa_checker.sv
bench/refcounted_page_allocator_tb.sv
